// ----- rtl/sblc_pkg.sv -----
// Shared types and constants for the size-budget LRU cache.
// No dependencies.
package sblc_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned KeyW   = 44;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned GenW   = 16;
  localparam int unsigned LimitW = 40;
  localparam int unsigned HeldW  = 41;
  localparam int unsigned EvW    = 7;

  localparam logic [OpW-1:0] OpProbe  = 3'd0;
  localparam logic [OpW-1:0] OpLookup = 3'd1;
  localparam logic [OpW-1:0] OpInsert = 3'd2;
  localparam logic [OpW-1:0] OpInval  = 3'd3;
  localparam logic [OpW-1:0] OpNewDoc = 3'd4;

  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic evict_last;
    logic write_slot;
    logic stamp_slot;
    logic drop_sel;
    logic clear_all;
    logic bump_gen;
    logic add_size;
  } sblc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic have_free;
    logic have_oldest;
    logic over_budget;
  } sblc_sts_t;

endpackage

// ----- rtl/sblc_ctrl.sv -----
// Controller state machine of the size-budget LRU cache.
// Depends on sblc_pkg.
module sblc_ctrl import sblc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [OpW-1:0] op_i,
  input  logic           accept_ok_i,
  input  sblc_sts_t      sts_i,
  output sblc_cmd_t      cmd_o,
  output logic           done_o,
  output logic           acc_o,
  input  logic           out_free_i
);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SScan  = 7'b0000010,
    SApply = 7'b0000100,
    SEvScn = 7'b0001000,
    SEvDo  = 7'b0010000,
    SDone  = 7'b0100000,
    SFull  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [OpW-1:0] op_q;
  logic acc_q, acc_d;

  assign in_ready_o = (state_q == SIdle);
  assign acc_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      op_q    <= OpProbe;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (in_valid_i && in_ready_o) op_q <= op_i;
    end
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          acc_d = 1'b0;
          if (op_i == OpInval || op_i == OpNewDoc) begin
            cmd_o.clear_all = 1'b1;
            cmd_o.bump_gen  = (op_i == OpNewDoc);
            state_d = SDone;
          end else if (op_i <= OpInsert) begin
            cmd_o.scan_start = 1'b1;
            state_d = SScan;
          end else begin
            state_d = SDone;
          end
        end
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = SApply;
      end
      SApply: begin
        if (op_q == OpLookup) begin
          cmd_o.stamp_slot = sts_i.found;
          state_d = SDone;
        end else if (op_q == OpInsert && accept_ok_i) begin
          acc_d = 1'b1;
          if (sts_i.found || sts_i.have_free) begin
            cmd_o.write_slot = 1'b1;
            cmd_o.add_size   = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d = SEvScn;
          end else begin
            cmd_o.drop_sel = 1'b1;
            state_d = SFull;
          end
        end else begin
          state_d = SDone;
        end
      end
      SFull: begin
        cmd_o.write_slot = 1'b1;
        cmd_o.add_size   = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d = SEvScn;
      end
      SEvScn: begin
        if (!sts_i.over_budget) begin
          state_d = SDone;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_done) state_d = SEvDo;
        end
      end
      SEvDo: begin
        if (sts_i.have_oldest) begin
          cmd_o.drop_sel   = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d = SEvScn;
        end else begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == SDone) else $error("result outside done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_slot |-> (state_q == SApply || state_q == SFull))
    else $error("write outside apply");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFull) |-> $past(state_q) == SApply) else $error("bad full entry");

endmodule

// ----- rtl/sblc_dp.sv -----
// Datapath of the size-budget LRU cache: entry memories, slot scanner,
// byte total, access clock and generation. Depends on sblc_pkg.
module sblc_dp import sblc_pkg::*; #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [SizeW-1:0]  size_i,
  input  logic [GenW-1:0]   tgen_i,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_data_i,
  input  sblc_cmd_t         cmd_i,
  output sblc_sts_t         sts_o,
  output logic              accept_ok_o,
  output logic              hit_o,
  output logic [EvW-1:0]    evicted_o,
  output logic [LimitW-1:0] mem_used_o,
  output logic [GenW-1:0]   gen_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]    valid_q;
  logic [KeyW-1:0]       key_mem [ENTRIES];
  logic [SizeW-1:0]      size_mem [ENTRIES];
  logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

  logic [KeyW-1:0]       key_q;
  logic [SizeW-1:0]      size_q;
  logic [GenW-1:0]       tgen_q;
  logic [LimitW-1:0]     limit_q;
  logic [HeldW-1:0]      held_q;
  logic [STAMP_BITS-1:0] clock_q;
  logic [GenW-1:0]       gen_q;
  logic [EvW-1:0]        ev_q;

  logic [CntW-1:0]       ptr_q;
  logic                  rd_v_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [KeyW-1:0]       rd_key_q;
  logic [STAMP_BITS-1:0] rd_stamp_q;
  logic                  found_q, free_q, old_q;
  logic [IdxW-1:0]       hit_idx_q, free_idx_q, old_idx_q, sel_idx;
  logic [STAMP_BITS-1:0] old_age_q, rd_age;
  logic                  scan_done;
  logic [SizeW-1:0]      drop_size_q;
  logic [SizeW-1:0]      hit_size_q;
  logic                  hit_q;
  logic                  first_q;

  assign rd_age    = clock_q - rd_stamp_q;
  assign scan_done = (ptr_q == CntW'(ENTRIES)) && !rd_v_q;
  assign sel_idx   = found_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);

  always_ff @(posedge clk_i) begin
    if (ptr_q < CntW'(ENTRIES)) begin
      rd_key_q   <= key_mem[ptr_q[IdxW-1:0]];
      rd_stamp_q <= stamp_mem[ptr_q[IdxW-1:0]];
      rd_idx_q   <= ptr_q[IdxW-1:0];
    end
    drop_size_q <= size_mem[old_idx_q];
    hit_size_q  <= size_mem[hit_idx_q];
    if (cmd_i.write_slot) begin
      key_mem[sel_idx]   <= key_q;
      size_mem[sel_idx]  <= size_q;
      stamp_mem[sel_idx] <= clock_q + STAMP_BITS'(1);
    end else if (cmd_i.stamp_slot) begin
      stamp_mem[hit_idx_q] <= clock_q + STAMP_BITS'(1);
    end
    if (load_i) begin
      key_q  <= key_i;
      size_q <= size_i;
      tgen_q <= tgen_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      limit_q <= LimitW'(268435456);
      held_q  <= '0;
      clock_q <= '0;
      gen_q   <= '0;
      ev_q    <= '0;
      ptr_q   <= CntW'(ENTRIES);
      rd_v_q  <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      old_q   <= 1'b0;
      hit_q   <= 1'b0;
      first_q <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      old_idx_q  <= '0;
      old_age_q  <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (load_i) begin
        ev_q    <= '0;
        hit_q   <= 1'b0;
        first_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        ptr_q   <= '0;
        rd_v_q  <= 1'b0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
        old_q   <= 1'b0;
        old_age_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (ptr_q < CntW'(ENTRIES)) ptr_q <= ptr_q + CntW'(1);
        rd_v_q <= (ptr_q < CntW'(ENTRIES));
        if (rd_v_q) begin
          if (valid_q[rd_idx_q]) begin
            if (rd_key_q == key_q && !found_q) begin
              found_q   <= 1'b1;
              hit_idx_q <= rd_idx_q;
            end
            if (!old_q || rd_age > old_age_q) begin
              old_q     <= 1'b1;
              old_idx_q <= rd_idx_q;
              old_age_q <= rd_age;
            end
          end else if (!free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
        end
      end
      if (scan_done && cmd_i.scan_step && first_q) begin
        hit_q   <= found_q;
        first_q <= 1'b0;
      end
      if (cmd_i.stamp_slot || cmd_i.write_slot) clock_q <= clock_q + STAMP_BITS'(1);
      if (cmd_i.write_slot) valid_q[sel_idx] <= 1'b1;
      if (cmd_i.add_size) held_q <= held_q + HeldW'(size_q) -
                                    (found_q ? HeldW'(hit_size_q) : HeldW'(0));
      if (cmd_i.drop_sel) begin
        valid_q[old_idx_q] <= 1'b0;
        held_q <= held_q - HeldW'(drop_size_q);
        if (ev_q != {EvW{1'b1}}) ev_q <= ev_q + EvW'(1);
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end
      if (cmd_i.clear_all) begin
        valid_q <= '0;
        held_q  <= '0;
      end
      if (cmd_i.bump_gen) gen_q <= gen_q + GenW'(1);
    end
  end

  assign sts_o.scan_done   = scan_done;
  assign sts_o.found       = found_q;
  assign sts_o.have_free   = free_q;
  assign sts_o.have_oldest = old_q;
  assign sts_o.over_budget = held_q > HeldW'(limit_q);
  assign accept_ok_o = (size_q != '0) && (tgen_q == gen_q);
  assign hit_o       = hit_q;
  assign evicted_o   = ev_q;
  assign mem_used_o  = held_q[HeldW-1] ? {LimitW{1'b1}} : held_q[LimitW-1:0];
  assign gen_o       = gen_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_all |=> held_q == '0) else $error("clear left bytes");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write_slot || cmd_i.stamp_slot) |=> clock_q == $past(clock_q) + STAMP_BITS'(1))
    else $error("clock not advanced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bump_gen |-> cmd_i.clear_all) else $error("bump without clear");

endmodule

// ----- rtl/size_budget_lru_cache.sv -----
// A probe or lookup runs one slot scan; a stored insert scans, writes the slot (after
// dropping the oldest entry on a full table) and rescans to evict while over the budget.
// Invalidate and new document skip the scan.
// Throughput: one request at a time; the slot scan over the entry memories sets it.
// A finished result sits in an output register while the next request is taken.
// Reset clears valid bits, byte total, access clock and generation at once.
// Top level; depends on sblc_pkg, sblc_ctrl and sblc_dp.
module size_budget_lru_cache import sblc_pkg::*; #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[2:0], page[18:3], width[32:19], height[46:33], size_bytes[78:47],
  // tag_generation[94:79], zero [95]
  input  logic [95:0]       s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // hit[0], needs_render[1], accepted[2], evicted_count[9:3],
  // memory_used[49:10], current_generation[65:50], zero [71:66]
  output logic [71:0]       m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i
);

  sblc_cmd_t cmd;
  sblc_sts_t sts;
  logic done, acc, ok, hit, load;
  logic [EvW-1:0] ev;
  logic [LimitW-1:0] used;
  logic [GenW-1:0] gen;
  logic [OpW-1:0] op_q;
  logic out_v_q;
  logic [71:0] out_q;

  assign load = s_axis_tvalid && s_axis_tready;

  sblc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tdata[2:0]), .accept_ok_i(ok), .sts_i(sts), .cmd_o(cmd),
    .done_o(done), .acc_o(acc), .out_free_i(!out_v_q || m_axis_tready)
  );

  sblc_dp #(.ENTRIES(ENTRIES), .STAMP_BITS(STAMP_BITS)) u_dp (
    .clk_i, .rst_ni, .load_i(load),
    .key_i({s_axis_tdata[18:3], s_axis_tdata[32:19], s_axis_tdata[46:33]}),
    .size_i(s_axis_tdata[78:47]), .tgen_i(s_axis_tdata[94:79]),
    .cfg_we_i, .cfg_data_i(cfg_wdata_i), .cmd_i(cmd), .sts_o(sts),
    .accept_ok_o(ok), .hit_o(hit), .evicted_o(ev), .mem_used_o(used), .gen_o(gen)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      op_q    <= OpProbe;
    end else begin
      if (load) op_q <= s_axis_tdata[2:0];
      if (done) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= {6'd0, gen, used, ev,
                acc && op_q == OpInsert,
                !sts.found && op_q == OpProbe,
                sts.found && op_q <= OpLookup || hit && op_q == OpInsert};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for size_budget_lru_cache: random bursts of cache requests
// are driven on the stream port and each result is compared with a built-in predictor.
// Depends on sblc_pkg and the size_budget_lru_cache RTL.
module testbench;
  import sblc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 64;

  typedef struct packed {
    logic [15:0] cur_gen;
    logic [39:0] mem_used;
    logic [6:0]  n_evicted;
    logic        accepted;
    logic        needs_render;
    logic        hit;
  } cache_result_t;

  class cache_scoreboard;
    bit          valid[Slots];
    logic [43:0] key[Slots];
    logic [31:0] size[Slots];
    logic [31:0] stamp[Slots];
    logic [40:0] held;
    logic [31:0] clock_now;
    logic [15:0] gen;
    logic [39:0] budget;
    cache_result_t pending[$];
    int errors;

    function void init();
      foreach (valid[i]) valid[i] = 0;
      held = 0; clock_now = 0; gen = 0; budget = 40'd268435456;
      errors = 0;
    endfunction

    function int oldest_slot();
      int best;
      logic [31:0] best_age, age;
      best = -1; best_age = 0;
      for (int i = 0; i < Slots; i++)
        if (valid[i]) begin
          age = clock_now - stamp[i];
          if (best < 0 || age > best_age) begin
            best = i; best_age = age;
          end
        end
      return best;
    endfunction

    function void note_request(logic [95:0] d);
      logic [2:0] op;
      logic [43:0] k;
      logic [31:0] sz;
      logic [15:0] tg;
      int s, v, ev;
      cache_result_t r;
      op = d[2:0]; k = {d[18:3], d[32:19], d[46:33]}; sz = d[78:47]; tg = d[94:79];
      r = '0; ev = 0; s = -1;
      if (op <= OpInsert) begin
        for (int i = 0; i < Slots; i++)
          if (s < 0 && valid[i] && key[i] == k) s = i;
        r.hit = s >= 0;
        if (op == OpProbe) r.needs_render = s < 0;
        else if (op == OpLookup) begin
          if (s >= 0) begin clock_now++; stamp[s] = clock_now; end
        end else if (sz != 0 && tg == gen) begin
          r.accepted = 1;
          if (s >= 0) held -= size[s];
          else begin
            for (int i = 0; i < Slots; i++) if (s < 0 && !valid[i]) s = i;
            if (s < 0) begin
              s = oldest_slot(); held -= size[s]; valid[s] = 0; ev++;
            end
          end
          valid[s] = 1; key[s] = k; size[s] = sz;
          clock_now++; stamp[s] = clock_now;
          held += sz;
          while (held > budget) begin
            v = oldest_slot();
            if (v < 0) break;
            held -= size[v]; valid[v] = 0; ev++;
          end
        end
      end else if (op == OpInval || op == OpNewDoc) begin
        foreach (valid[i]) valid[i] = 0;
        held = 0;
        if (op == OpNewDoc) gen++;
      end
      r.n_evicted = ev > 127 ? 7'd127 : 7'(ev);
      r.mem_used = held[40] ? '1 : held[39:0];
      r.cur_gen = gen;
      pending.push_back(r);
    endfunction

    function void check_result(logic [71:0] d);
      cache_result_t got, exp_r;
      got = d[65:0];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r || d[71:66] !== '0) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp hit=%0d nr=%0d acc=%0d ev=%0d mem=%0d gen=%0d",
                    " | got hit=%0d nr=%0d acc=%0d ev=%0d mem=%0d gen=%0d"},
                   exp_r.hit, exp_r.needs_render, exp_r.accepted, exp_r.n_evicted,
                   exp_r.mem_used, exp_r.cur_gen, got.hit, got.needs_render, got.accepted,
                   got.n_evicted, got.mem_used, got.cur_gen);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready, m_axis_tvalid, m_axis_tready = 0;
  logic [95:0] s_axis_tdata = '0;
  logic [71:0] m_axis_tdata;
  logic cfg_we_i = 0;
  logic [LimitW-1:0] cfg_wdata_i = '0;
  cache_scoreboard sb;
  int unsigned cycles = 0;
  int stall_mode = 0;

  size_budget_lru_cache dut (.*);

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= (cycles % 16) < 5;
    endcase
  end

  logic [15:0] pages[8];
  logic [13:0] wds[8], hts[8];

  function automatic logic [95:0] pack_req(logic [2:0] op, logic [15:0] pg, logic [13:0] w,
                                           logic [13:0] h, logic [31:0] sz, logic [15:0] tg);
    return {1'b0, tg, sz, h, w, pg, op};
  endfunction

  task automatic send(logic [95:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(d);
  endtask

  task automatic gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic set_budget(logic [39:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.budget = v;
  endtask

  task automatic random_request();
    int sel, k;
    logic [2:0] op;
    logic [31:0] sz;
    logic [15:0] tg;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    if (sel < 30) op = OpProbe;
    else if (sel < 50) op = OpLookup;
    else if (sel < 92) op = OpInsert;
    else if (sel < 95) op = OpInval;
    else if (sel < 97) op = OpNewDoc;
    else op = 3'($urandom_range(5, 7));
    sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4000);
    tg = ($urandom_range(0, 7) == 0) ? 16'($urandom) : sb.gen;
    if ($urandom_range(0, 9) == 0)
      send(pack_req(op, 16'($urandom), 14'($urandom), 14'($urandom), sz, tg));
    else
      send(pack_req(op, pages[k] + 16'($urandom_range(0, 9)), wds[k], hts[k], sz, tg));
  endtask

  initial begin
    sb = new();
    sb.init();
    foreach (pages[i]) begin
      pages[i] = 16'($urandom); wds[i] = 14'($urandom); hts[i] = 14'($urandom);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send(pack_req(OpProbe, 16'hFFFF, 14'h3FFF, 14'h3FFF, 32'd0, 16'd0));
    send(pack_req(OpInsert, 16'hFFFF, 14'h3FFF, 14'h3FFF, 32'd0, 16'd0));
    send(pack_req(OpInsert, 16'hFFFF, 14'h3FFF, 14'h3FFF, 32'd100, 16'hFFFF));
    send(pack_req(OpInsert, 16'hFFFF, 14'h3FFF, 14'h3FFF, 32'd100, 16'd0));
    send(pack_req(OpProbe, 16'hFFFF, 14'h3FFF, 14'h3FFF, 32'd0, 16'd0));
    send(pack_req(OpLookup, 16'hFFFF, 14'h3FFF, 14'h3FFF, 32'd0, 16'd0));
    send(pack_req(OpInsert, 16'd0, 14'd0, 14'd0, 32'hFFFF_FFFF, 16'd0));
    send(pack_req(OpInsert, 16'hFFFF, 14'h3FFF, 14'h3FFF, 32'd50, 16'd0));
    send(pack_req(OpLookup, 16'd1, 14'd2, 14'd3, 32'd0, 16'd0));
    send(pack_req(3'd5, 16'd0, 14'd0, 14'd0, 32'd0, 16'd0));
    send(pack_req(3'd7, 16'd0, 14'd0, 14'd0, 32'd0, 16'd0));
    send(pack_req(OpInval, 16'd0, 14'd0, 14'd0, 32'd0, 16'd0));
    send(pack_req(OpNewDoc, 16'd0, 14'd0, 14'd0, 32'd0, 16'd0));
    send(pack_req(OpInsert, 16'd5, 14'd5, 14'd5, 32'd10, 16'd1));
    drain();
    set_budget(40'hFF_FFFF_FFFF);
    for (int i = 0; i < 70; i++)
      send(pack_req(OpInsert, 16'(i), 14'(i), 14'd0, 32'hFFFF_FFFF, 16'd1));
    drain();
    set_budget(40'd0);
    send(pack_req(OpInsert, 16'd9, 14'd9, 14'd9, 32'd1, 16'd1));
    send(pack_req(OpNewDoc, 16'd0, 14'd0, 14'd0, 32'd0, 16'd0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_budget(ph == 0 ? 40'd20000 : ph == 1 ? 40'd5000 : ph == 2 ? 40'd268435456
                 : 40'hFF_FFFF_FFFF);
      stall_mode = ph % 3;
      for (int n = 0; n < 120; ) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++, n++) random_request();
        if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 80));
      end
      drain();
    end

    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
